>>> rtl/gvwa_pkg.sv
`default_nettype none
package gvwa_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_WINDOW_LEN    = 2'd0;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 14;
    localparam int WINDOW_BITS    = 6;
    localparam int SCREEN_BITS    = 14;

    // Reset values of the configuration registers
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 6'd12;
    localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = 14'd1920;
    localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 14'd1080;

    // Screen scaling: v * 65535 = (v << 16) - v
    localparam int SCALE_SHIFT = 16;
    localparam int SCALED_BITS = 32;
    localparam logic [SCALED_BITS-1:0] SCALED_MAX = 32'h7FFF_FFFF;
    localparam logic [SCALED_BITS-1:0] SCALED_MIN = 32'h8000_0000;

    // Divisor width of the shared divider (screen size, also holds the count)
    localparam int DIVISOR_BITS = 14;

    // Divider jobs
    typedef logic [1:0] div_op_t;
    localparam div_op_t OP_AVG_I = 2'd0;
    localparam div_op_t OP_AVG_J = 2'd1;
    localparam div_op_t OP_SCL_X = 2'd2;
    localparam div_op_t OP_SCL_Y = 2'd3;

endpackage
`default_nettype wire

>>> rtl/gvwa_ring_ram.sv
`default_nettype none
module gvwa_ring_ram #(
    parameter int DEPTH     = 60,
    parameter int WIDTH     = 33,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one sample
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/gvwa_div.sv
`default_nettype none
module gvwa_div import gvwa_pkg::*; #(
    parameter int DIVIDEND_BITS = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output logic                          busy,
    output logic                          done,
    output logic      [DIVIDEND_BITS-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  dvsr_reg;

    logic [DIVISOR_BITS:0]    rem_shift;
    logic [DIVISOR_BITS+1:0]  diff;
    logic                     fits;

    // One restoring step: shift in the next dividend bit, trial subtract
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvsr_reg};
    assign fits      = ~diff[DIVISOR_BITS+1];

    // Sequence control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIVIDEND_BITS);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a running division");

endmodule
`default_nettype wire

>>> rtl/gaze_validity_window_average_top.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------------------
// s_ input  | s_valid / s_ready    | s_eye_found, s_gaze_i, s_gaze_j
// m_ result | m_valid / m_ready    | m_smooth_i, m_smooth_j, m_scaled_x, m_scaled_y,
//           |                      | m_scaled_updated
// cfg write | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request at a time. After accept, the ring walk reads one ring memory entry
// per window entry, then the divisions run on the shared serial divider: two
// when a found sample lies in the window, two more when the current sample is
// found. Last the result register is loaded.
// Reset clears the found-valid flags of all ring entries at once; no sweep.
// A new request is taken while the previous result still waits on m_ready.
`default_nettype none
module gaze_validity_window_average_top import gvwa_pkg::*; #(
    parameter int RING_DEPTH = 60,
    parameter int COORD_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_eye_found,
    input  wire logic signed [COORD_BITS-1:0]  s_gaze_i,
    input  wire logic signed [COORD_BITS-1:0]  s_gaze_j,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [COORD_BITS-1:0]       m_smooth_i,
    output logic signed [COORD_BITS-1:0]       m_smooth_j,
    output logic signed [SCALED_BITS-1:0]      m_scaled_x,
    output logic signed [SCALED_BITS-1:0]      m_scaled_y,
    output logic                               m_scaled_updated
);

    localparam int AW      = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > WINDOW_BITS) ? CNT_W : WINDOW_BITS;
    localparam int SUM_W   = COORD_BITS + CNT_W;
    localparam int PROD_W  = COORD_BITS + SCALE_SHIFT;
    localparam int ENTRY_W = 2 * COORD_BITS + 1;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_WALK     = 3'd1;
    localparam logic [2:0] ST_DRAIN    = 3'd2;
    localparam logic [2:0] ST_DECIDE   = 3'd3;
    localparam logic [2:0] ST_DIV_GO   = 3'd4;
    localparam logic [2:0] ST_DIV_WAIT = 3'd5;
    localparam logic [2:0] ST_OUT      = 3'd6;

    logic [2:0]                    state_reg;
    logic [WINDOW_BITS-1:0]        window_len_reg;
    logic [SCREEN_BITS-1:0]        screen_width_reg;
    logic [SCREEN_BITS-1:0]        screen_height_reg;
    logic [AW-1:0]                 slot_reg;
    logic [RING_DEPTH-1:0]         seen_reg;
    logic                          found_reg;
    logic [CNT_W-1:0]              win_reg;
    logic [CNT_W-1:0]              left_reg;
    logic [AW-1:0]                 walk_ptr_reg;
    logic                          rd_vld_reg;
    logic                          rd_ok_reg;
    logic signed [SUM_W-1:0]       sum_i_reg;
    logic signed [SUM_W-1:0]       sum_j_reg;
    logic [CNT_W-1:0]              count_reg;
    div_op_t                       op_reg;
    logic                          neg_reg;
    logic signed [COORD_BITS-1:0]  held_smooth_i_reg;
    logic signed [COORD_BITS-1:0]  held_smooth_j_reg;
    logic signed [SCALED_BITS-1:0] held_scaled_x_reg;
    logic signed [SCALED_BITS-1:0] held_scaled_y_reg;
    logic                          m_valid_reg;
    logic signed [COORD_BITS-1:0]  m_smooth_i_reg;
    logic signed [COORD_BITS-1:0]  m_smooth_j_reg;
    logic signed [SCALED_BITS-1:0] m_scaled_x_reg;
    logic signed [SCALED_BITS-1:0] m_scaled_y_reg;
    logic                          m_scaled_updated_reg;

    logic                          s_accept;
    logic                          out_load;
    logic [AW-1:0]                 slot_next;
    logic [CMP_W-1:0]              wl_ext;
    logic [CNT_W-1:0]              win_clamped;
    logic [ENTRY_W-1:0]            rd_data;
    logic                          rd_found;
    logic signed [COORD_BITS-1:0]  rd_i;
    logic signed [COORD_BITS-1:0]  rd_j;
    logic                          take_entry;

    logic signed [SUM_W-1:0]       sum_sel;
    logic                          sum_neg;
    logic [SUM_W-1:0]              sum_mag;
    logic signed [COORD_BITS-1:0]  coord_sel;
    logic                          coord_neg;
    logic [COORD_BITS-1:0]         coord_mag;
    logic [PROD_W-1:0]             prod;
    logic [SCREEN_BITS-1:0]        size_sel;
    logic                          is_avg;
    logic                          op_neg;
    logic [PROD_W-1:0]             div_dividend;
    logic [DIVISOR_BITS-1:0]       div_divisor;
    logic                          div_start;
    logic                          div_busy;
    logic                          div_done;
    logic [PROD_W-1:0]             div_quotient;
    logic [COORD_BITS-1:0]         avg_mag;
    logic signed [COORD_BITS-1:0]  avg_result;
    logic [63:0]                   q_wide;
    logic signed [SCALED_BITS-1:0] scl_result;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Advance the write slot, wrapping at the ring depth
    assign slot_next = (slot_reg == AW'(RING_DEPTH - 1)) ? '0 : slot_reg + 1'b1;

    // Clamp the window to one through ring depth
    assign wl_ext = CMP_W'(window_len_reg);
    always_comb begin
        if (window_len_reg == '0) begin
            win_clamped = CNT_W'(1);
        end else if (wl_ext > CMP_W'(RING_DEPTH)) begin
            win_clamped = CNT_W'(RING_DEPTH);
        end else begin
            win_clamped = CNT_W'(wl_ext);
        end
    end

    gvwa_ring_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (slot_next),
        .wr_data ({s_eye_found, s_gaze_i, s_gaze_j}),
        .rd_en   (state_reg == ST_WALK),
        .rd_addr (walk_ptr_reg),
        .rd_data (rd_data)
    );

    assign rd_found   = rd_data[ENTRY_W-1];
    assign rd_i       = rd_data[2*COORD_BITS-1:COORD_BITS];
    assign rd_j       = rd_data[COORD_BITS-1:0];
    assign take_entry = rd_vld_reg && rd_ok_reg && rd_found;

    // Select divider operands for the current job
    assign is_avg  = (op_reg == OP_AVG_I) || (op_reg == OP_AVG_J);
    assign sum_sel = (op_reg == OP_AVG_I) ? sum_i_reg : sum_j_reg;
    assign sum_neg = sum_sel[SUM_W-1];
    assign sum_mag = sum_neg ? -sum_sel : sum_sel;

    assign coord_sel = (op_reg == OP_SCL_X) ? held_smooth_i_reg : held_smooth_j_reg;
    assign coord_neg = coord_sel[COORD_BITS-1];
    assign coord_mag = coord_neg ? -coord_sel : coord_sel;
    assign prod      = (PROD_W'(coord_mag) << SCALE_SHIFT) - PROD_W'(coord_mag);
    assign size_sel  = (op_reg == OP_SCL_X) ? screen_width_reg : screen_height_reg;

    always_comb begin
        if (is_avg) begin
            op_neg       = sum_neg;
            div_dividend = PROD_W'(sum_mag);
            div_divisor  = DIVISOR_BITS'(count_reg);
        end else begin
            op_neg       = coord_neg;
            div_dividend = prod;
            div_divisor  = (size_sel == '0) ? DIVISOR_BITS'(1) : size_sel;
        end
    end

    assign div_start = (state_reg == ST_DIV_GO);

    gvwa_div #(
        .DIVIDEND_BITS (PROD_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Restore the sign, truncated toward zero
    assign avg_mag    = COORD_BITS'(div_quotient);
    assign avg_result = neg_reg ? -avg_mag : avg_mag;

    // Saturate the scaled value to the signed 32-bit range
    assign q_wide = 64'(div_quotient);
    always_comb begin
        if (neg_reg) begin
            scl_result = (q_wide > 64'h0000_0000_8000_0000) ? SCALED_MIN
                                                            : SCALED_BITS'(64'd0 - q_wide);
        end else begin
            scl_result = (q_wide > 64'h0000_0000_7FFF_FFFF) ? SCALED_MAX
                                                            : SCALED_BITS'(q_wide);
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg    <= WINDOW_RESET;
            screen_width_reg  <= WIDTH_RESET;
            screen_height_reg <= HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WINDOW_LEN:    window_len_reg    <= WINDOW_BITS'(cfg_data);
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: store, walk the window, divide, publish
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            slot_reg          <= '0;
            seen_reg          <= '0;
            rd_vld_reg        <= 1'b0;
            held_smooth_i_reg <= '0;
            held_smooth_j_reg <= '0;
            held_scaled_x_reg <= '0;
            held_scaled_y_reg <= '0;
        end else begin
            rd_vld_reg <= (state_reg == ST_WALK);
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        slot_reg            <= slot_next;
                        seen_reg[slot_next] <= 1'b1;
                        state_reg           <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (left_reg == CNT_W'(1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (count_reg != '0 || found_reg) begin
                        state_reg <= ST_DIV_GO;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        case (op_reg)
                            OP_AVG_I: begin
                                held_smooth_i_reg <= avg_result;
                                state_reg         <= ST_DIV_GO;
                            end
                            OP_AVG_J: begin
                                held_smooth_j_reg <= avg_result;
                                state_reg         <= found_reg ? ST_DIV_GO : ST_OUT;
                            end
                            OP_SCL_X: begin
                                held_scaled_x_reg <= scl_result;
                                state_reg         <= ST_DIV_GO;
                            end
                            default: begin
                                held_scaled_y_reg <= scl_result;
                                state_reg         <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Walk pointer, sums and divider job
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            found_reg    <= s_eye_found;
            win_reg      <= win_clamped;
            left_reg     <= win_clamped;
            walk_ptr_reg <= slot_next;
            sum_i_reg    <= '0;
            sum_j_reg    <= '0;
            count_reg    <= '0;
        end else begin
            if (state_reg == ST_WALK) begin
                left_reg     <= left_reg - 1'b1;
                walk_ptr_reg <= (walk_ptr_reg == '0) ? AW'(RING_DEPTH - 1)
                                                     : walk_ptr_reg - 1'b1;
            end
            if (take_entry) begin
                sum_i_reg <= sum_i_reg + SUM_W'(rd_i);
                sum_j_reg <= sum_j_reg + SUM_W'(rd_j);
                count_reg <= count_reg + 1'b1;
            end
        end
        rd_ok_reg <= seen_reg[walk_ptr_reg];
        if (state_reg == ST_DECIDE) begin
            op_reg <= (count_reg != '0) ? OP_AVG_I : OP_SCL_X;
        end else if (state_reg == ST_DIV_WAIT && div_done) begin
            op_reg <= (op_reg == OP_AVG_J) ? OP_SCL_X : op_reg + 1'b1;
        end
        if (div_start) begin
            neg_reg <= op_neg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_smooth_i_reg       <= held_smooth_i_reg;
            m_smooth_j_reg       <= held_smooth_j_reg;
            m_scaled_x_reg       <= held_scaled_x_reg;
            m_scaled_y_reg       <= held_scaled_y_reg;
            m_scaled_updated_reg <= found_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_smooth_i       = m_smooth_i_reg;
    assign m_smooth_j       = m_smooth_j_reg;
    assign m_scaled_x       = m_scaled_x_reg;
    assign m_scaled_y       = m_scaled_y_reg;
    assign m_scaled_updated = m_scaled_updated_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken before the first finished");

    a_count_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DECIDE |-> count_reg <= win_reg)
        else $error("found count exceeds the window");

    a_div_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the publish step");

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import gvwa_pkg::*;

    localparam int RING = 60;
    localparam int CB = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_SAMPLES = 180;
    localparam int N_DIR = 33;

    typedef struct packed {
        logic signed [CB-1:0] smooth_i;
        logic signed [CB-1:0] smooth_j;
        logic signed [31:0]   scaled_x;
        logic signed [31:0]   scaled_y;
        logic                 updated;
    } gaze_result_t;

    typedef struct packed {
        logic                          is_write;
        logic [CFG_INDEX_BITS-1:0]     reg_idx;
        logic [CFG_DATA_BITS-1:0]      reg_val;
        logic                          found;
        logic signed [CB-1:0]          gi;
        logic signed [CB-1:0]          gj;
        logic                          typed;
        gaze_result_t                  want;
    } gaze_step_t;

    localparam gaze_result_t NO_TYPED = '{16'sd0, 16'sd0, 32'sd0, 32'sd0, 1'b0};

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic s_eye_found;
    logic signed [CB-1:0] s_gaze_i;
    logic signed [CB-1:0] s_gaze_j;
    logic m_valid;
    logic m_ready;
    logic signed [CB-1:0] m_smooth_i;
    logic signed [CB-1:0] m_smooth_j;
    logic signed [31:0] m_scaled_x;
    logic signed [31:0] m_scaled_y;
    logic m_scaled_updated;

    // Predictor copy of the configuration and the sample ring
    logic [WINDOW_BITS-1:0] cfg_window = WINDOW_RESET;
    logic [SCREEN_BITS-1:0] cfg_width = WIDTH_RESET;
    logic [SCREEN_BITS-1:0] cfg_height = HEIGHT_RESET;
    logic ring_found [RING];
    logic signed [CB-1:0] ring_i [RING];
    logic signed [CB-1:0] ring_j [RING];
    int unsigned ring_slot = 0;
    logic signed [CB-1:0] held_i = '0;
    logic signed [CB-1:0] held_j = '0;
    logic signed [31:0] held_x = '0;
    logic signed [31:0] held_y = '0;

    gaze_result_t pending_results [$];
    logic override_on = 1'b0;
    gaze_result_t override_want = NO_TYPED;

    int samples_taken = 0;
    int found_taken = 0;
    int results_checked = 0;
    int writes_done = 0;
    int err_count = 0;
    int stall_cycles = 0;
    int s_idle_pct = 0;
    int r_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    // Directed sequence: register writes and samples, typed results where obvious
    gaze_step_t dir_steps [N_DIR] = '{
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b0, 16'sh7FFF, 16'sh8000, 1'b1,
          '{16'sd0, 16'sd0, 32'sd0, 32'sd0, 1'b0}},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, 16'sd1920, 16'sd1080, 1'b1,
          '{16'sd1920, 16'sd1080, 32'sd65535, 32'sd65535, 1'b1}},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b0, 16'sd5, 16'sd5, 1'b1,
          '{16'sd1920, 16'sd1080, 32'sd65535, 32'sd65535, 1'b0}},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, -16'sd1920, -16'sd1080, 1'b1,
          '{16'sd0, 16'sd0, 32'sd0, 32'sd0, 1'b1}},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, 16'sh7FFF, 16'sh7FFF, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, 16'sh8000, 16'sh8000, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, 16'sh7FFF, 16'sh8000, 1'b0, NO_TYPED},
        '{1'b1, REG_WINDOW_LEN, 14'd1, 1'b0, 16'sd0, 16'sd0, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, 16'sh7FFF, 16'sh8000, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b0, -16'sd1, -16'sd1, 1'b0, NO_TYPED},
        '{1'b1, REG_WINDOW_LEN, 14'h3FC0, 1'b0, 16'sd0, 16'sd0, 1'b0, NO_TYPED},
        '{1'b1, REG_SCREEN_WIDTH, 14'd0, 1'b0, 16'sd0, 16'sd0, 1'b0, NO_TYPED},
        '{1'b1, REG_SCREEN_HEIGHT, 14'd0, 1'b0, 16'sd0, 16'sd0, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, 16'sh8000, 16'sh7FFF, 1'b1,
          '{16'sh8000, 16'sh7FFF, -32'sd2147450880, 32'sd2147385345, 1'b1}},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, -16'sd7, 16'sd7, 1'b1,
          '{-16'sd7, 16'sd7, -32'sd458745, 32'sd458745, 1'b1}},
        '{1'b1, REG_WINDOW_LEN, 14'd63, 1'b0, 16'sd0, 16'sd0, 1'b0, NO_TYPED},
        '{1'b1, REG_SCREEN_WIDTH, 14'd16383, 1'b0, 16'sd0, 16'sd0, 1'b0, NO_TYPED},
        '{1'b1, REG_SCREEN_HEIGHT, 14'd8192, 1'b0, 16'sd0, 16'sd0, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, -16'sd1, -16'sd1, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, 16'sd0, 16'sd0, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b0, 16'sh7FFF, 16'sh7FFF, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, 16'sd12345, -16'sd12345, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b0, 16'sh8000, 16'sh8000, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, 16'sd1, -16'sd1, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, 16'sh8000, 16'sh8000, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, 16'sh7FFF, 16'sh7FFF, 1'b0, NO_TYPED},
        '{1'b1, REG_WINDOW_LEN, 14'd60, 1'b0, 16'sd0, 16'sd0, 1'b0, NO_TYPED},
        '{1'b1, REG_SCREEN_WIDTH, 14'd1, 1'b0, 16'sd0, 16'sd0, 1'b0, NO_TYPED},
        '{1'b1, REG_SCREEN_HEIGHT, 14'd1, 1'b0, 16'sd0, 16'sd0, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, 16'sh7FFF, 16'sh7FFF, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b0, 16'sd0, 16'sd0, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, 16'sh8000, 16'sh8000, 1'b0, NO_TYPED},
        '{1'b0, REG_WINDOW_LEN, 14'd0, 1'b1, -16'sd3, 16'sd3, 1'b0, NO_TYPED}
    };

    gaze_validity_window_average_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_eye_found     (s_eye_found),
        .s_gaze_i        (s_gaze_i),
        .s_gaze_j        (s_gaze_j),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_smooth_i      (m_smooth_i),
        .m_smooth_j      (m_smooth_j),
        .m_scaled_x      (m_scaled_x),
        .m_scaled_y      (m_scaled_y),
        .m_scaled_updated(m_scaled_updated)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Scale a smoothed coordinate by 65535 / screen size, saturating to signed 32 bits
    function automatic logic signed [31:0] screen_scale(longint v, int unsigned size);
        longint d;
        longint q;
        d = (size == 0) ? 64'sd1 : longint'(size);
        q = (v * 65535) / d;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return 32'(q);
    endfunction

    // Store the sample, average the found entries in the window (held if none), rescale if found
    function automatic gaze_result_t predict_gaze(logic found, logic signed [CB-1:0] gi,
                                                  logic signed [CB-1:0] gj);
        gaze_result_t r;
        int unsigned win;
        int unsigned n;
        int unsigned hits;
        int unsigned k;
        longint sum_i;
        longint sum_j;
        win = (cfg_window == 0) ? 1 : ((cfg_window > RING) ? RING : cfg_window);
        ring_slot = (ring_slot + 1) % RING;
        ring_found[ring_slot] = found;
        ring_i[ring_slot] = gi;
        ring_j[ring_slot] = gj;
        n = ring_slot;
        hits = 0;
        sum_i = 0;
        sum_j = 0;
        for (k = 0; k < win; k++) begin
            if (ring_found[n]) begin
                hits++;
                sum_i += ring_i[n];
                sum_j += ring_j[n];
            end
            n = (n == 0) ? RING - 1 : n - 1;
        end
        if (hits > 0) begin
            held_i = CB'(sum_i / longint'(hits));
            held_j = CB'(sum_j / longint'(hits));
        end
        if (found) begin
            held_x = screen_scale(held_i, cfg_width);
            held_y = screen_scale(held_j, cfg_height);
        end
        r.smooth_i = held_i;
        r.smooth_j = held_j;
        r.scaled_x = held_x;
        r.scaled_y = held_y;
        r.updated = found;
        return r;
    endfunction

    task automatic report_error(string msg);
        err_count++;
        if (err_count <= 30) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Hold the sender until every pending result is back
    task automatic wait_all_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        int target;
        wait_all_results();
        target = writes_done + 1;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge aclk); while (writes_done != target);
        cfg_valid <= 1'b0;
    endtask

    // Offer one gaze request after a random gap; return once it is taken
    task automatic push_sample(logic found, logic signed [CB-1:0] gi, logic signed [CB-1:0] gj,
                               logic typed, gaze_result_t want);
        int target;
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        target = samples_taken + 1;
        override_on = typed;
        override_want = want;
        s_valid <= 1'b1;
        s_eye_found <= found;
        s_gaze_i <= gi;
        s_gaze_j <= gj;
        do @(negedge aclk); while (samples_taken != target);
    endtask

    function automatic logic signed [CB-1:0] pick_coord();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3, 4, 5: return CB'($urandom);
            default: return CB'(int'($urandom_range(2300)) - 200);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_window();
        case ($urandom_range(11))
            0: return 14'd0;
            1: return 14'd1;
            2: return 14'd2;
            3: return 14'd12;
            4: return 14'd59;
            5: return 14'd60;
            6: return 14'd61;
            7: return 14'd63;
            8: return CFG_DATA_BITS'($urandom);
            default: return CFG_DATA_BITS'($urandom_range(1, 60));
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_screen();
        case ($urandom_range(7))
            0: return 14'd0;
            1: return 14'd1;
            2: return 14'd8192;
            3: return 14'd16383;
            4: return WIDTH_RESET;
            5: return HEIGHT_RESET;
            default: return CFG_DATA_BITS'($urandom);
        endcase
    endfunction

    // Result side: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= r_idle_pct);
        end
    end

    // Track handshakes, predict on accept, compare results, watch for a hang
    always @(posedge aclk) begin
        gaze_result_t want;
        logic progress;
        progress = 1'b0;
        if (m_valid && m_ready) begin
            progress = 1'b1;
            if (pending_results.size() == 0) begin
                report_error("result with no request pending");
            end else begin
                want = pending_results.pop_front();
                if (m_smooth_i !== want.smooth_i)
                    report_error($sformatf("result %0d smooth_i %0d, want %0d",
                                           results_checked, m_smooth_i, want.smooth_i));
                if (m_smooth_j !== want.smooth_j)
                    report_error($sformatf("result %0d smooth_j %0d, want %0d",
                                           results_checked, m_smooth_j, want.smooth_j));
                if (m_scaled_x !== want.scaled_x)
                    report_error($sformatf("result %0d scaled_x %0d, want %0d",
                                           results_checked, m_scaled_x, want.scaled_x));
                if (m_scaled_y !== want.scaled_y)
                    report_error($sformatf("result %0d scaled_y %0d, want %0d",
                                           results_checked, m_scaled_y, want.scaled_y));
                if (m_scaled_updated !== want.updated)
                    report_error($sformatf("result %0d scaled_updated %0b, want %0b",
                                           results_checked, m_scaled_updated, want.updated));
            end
            results_checked++;
        end
        if (cfg_valid && cfg_ready) begin
            progress = 1'b1;
            case (cfg_index)
                REG_WINDOW_LEN: cfg_window = cfg_data[WINDOW_BITS-1:0];
                REG_SCREEN_WIDTH: cfg_width = cfg_data[SCREEN_BITS-1:0];
                REG_SCREEN_HEIGHT: cfg_height = cfg_data[SCREEN_BITS-1:0];
                default: ;
            endcase
            writes_done++;
        end
        if (s_valid && s_ready) begin
            progress = 1'b1;
            want = predict_gaze(s_eye_found, s_gaze_i, s_gaze_j);
            if (override_on) want = override_want;
            pending_results.push_back(want);
            samples_taken++;
            if (s_eye_found) found_taken++;
        end
        stall_cycles = progress ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        int i;
        int ph;
        int sent;
        int run;
        int k;
        int found_pct;
        logic paused;
        for (i = 0; i < RING; i++) ring_found[i] = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_WINDOW_LEN;
        cfg_data = '0;
        s_valid = 1'b0;
        s_eye_found = 1'b0;
        s_gaze_i = '0;
        s_gaze_j = '0;
        m_ready = 1'b0;
        paused = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed walk through the table
        for (i = 0; i < N_DIR; i++) begin
            if (dir_steps[i].is_write)
                write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_val);
            else
                push_sample(dir_steps[i].found, dir_steps[i].gi, dir_steps[i].gj,
                            dir_steps[i].typed, dir_steps[i].want);
        end

        // Random phases: bursts of mostly found, mixed or mostly lost samples
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            s_idle_pct = (ph < 2) ? 12 : ((ph < 4) ? 72 : 0);
            r_idle_pct = (ph < 2) ? 72 : ((ph < 4) ? 12 : 0);
            write_reg(REG_WINDOW_LEN, pick_window());
            write_reg(REG_SCREEN_WIDTH, pick_screen());
            write_reg(REG_SCREEN_HEIGHT, pick_screen());
            if (ph == 4) hold_request = 400;
            sent = 0;
            while (sent < PHASE_SAMPLES) begin
                run = $urandom_range(1, 24);
                case ($urandom_range(2))
                    0: found_pct = 90;
                    1: found_pct = 55;
                    default: found_pct = 8;
                endcase
                for (k = 0; k < run && sent < PHASE_SAMPLES; k++) begin
                    push_sample($urandom_range(99) < found_pct, pick_coord(), pick_coord(),
                                1'b0, NO_TYPED);
                    sent++;
                end
                // Pause the sender once until the block is empty
                if (ph == 2 && !paused && sent >= PHASE_SAMPLES / 2) begin
                    wait_all_results();
                    paused = 1'b1;
                end
            end
        end

        wait_all_results();
        repeat (300) @(negedge aclk);
        $display("tb_top: %0d gaze samples (%0d with eye found), %0d results checked",
                 samples_taken, found_taken, results_checked);
        $display("tb_top: %0d register writes, window and screen extremes, three stall mixes",
                 writes_done);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
